// ===== sv/crre_pkg.sv =====
// ----------------------------------------------------------------------------
// crre_pkg
// Shared types and constants of the chunked read reorder engine.
// ----------------------------------------------------------------------------
package crre_pkg;

    localparam int SLOTS   = 16;
    localparam int SECT_W  = 48;
    localparam int LEN_W   = 9;
    localparam int TAG_W   = 4;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 2;

    localparam logic [KIND_W-1:0] KIND_ISSUE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

    localparam logic [IDX_W-1:0] REG_START = 2'd0;
    localparam logic [IDX_W-1:0] REG_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHUNK = 2'd2;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_CPL   = 1'b1;

    typedef struct packed {
        logic             func;
        logic [TAG_W-1:0] tag;
        logic             error;
        logic             final_req;
    } t_in;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  slot;
        logic [SECT_W-1:0] sector;
        logic [LEN_W-1:0]  sectors;
        logic              failed;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [SECT_W-1:0] data;
    } t_cfg;

endpackage

// ===== sv/crre_if.sv =====
// ----------------------------------------------------------------------------
// crre_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface crre_in_if;
    import crre_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crre_out_if;
    import crre_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crre_cfg_if;
    import crre_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/crre_front.sv =====
// ----------------------------------------------------------------------------
// crre_front
// Two-entry queue that accepts input items ahead of the back end.
// ----------------------------------------------------------------------------
module crre_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  crre_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output crre_pkg::t_in  o_data
);
    import crre_pkg::*;

    t_in        r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== sv/crre_back.sv =====
// ----------------------------------------------------------------------------
// crre_back
// Sequencer that carries out one item: update, retire scan, issue loop.
// ----------------------------------------------------------------------------
module crre_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  crre_pkg::t_in  i_data,
    input  logic           i_cfg_we,
    input  crre_pkg::t_cfg i_cfg,
    output logic           o_valid,
    input  logic           i_ready,
    output crre_pkg::t_out o_data,
    output logic           o_idle
);
    import crre_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_ISSUE  = 3'd3;
    localparam logic [2:0] ST_RET    = 3'd4;

    localparam logic [1:0] SS_FREE = 2'd0;
    localparam logic [1:0] SS_PEND = 2'd1;
    localparam logic [1:0] SS_DONE = 2'd2;

    logic [SECT_W-1:0] r_start_cfg;
    logic [SECT_W-1:0] r_count_cfg;
    logic [LEN_W-1:0]  r_chunk;
    logic [SECT_W-1:0] r_slot_start [SLOTS];
    logic [LEN_W-1:0]  r_slot_len   [SLOTS];
    logic [1:0]        r_status     [SLOTS];
    logic [SW-1:0]     r_stack      [SLOTS];
    logic [CW-1:0]     r_free;
    logic [CW-1:0]     r_pend;
    logic [SECT_W-1:0] r_next_issue;
    logic [SECT_W-1:0] r_next_ret;
    logic [SECT_W-1:0] r_left;
    logic              r_err;
    logic [2:0]        r_state;
    logic [SW-1:0]     r_hit;
    logic              r_hit_ok;
    logic              r_hold;
    logic              r_ov;
    t_out              r_od;

    logic [LEN_W-1:0]  w_chunk;
    logic [LEN_W-1:0]  w_len;
    logic              w_can_issue;
    logic              w_hit_ok;
    logic [SW-1:0]     w_hit;
    logic              w_out_free;
    logic [SW-1:0]     w_top;
    logic [SW-1:0]     w_tag;
    logic              w_done;
    logic              w_emit;

    // Hold a fresh result back until it is known whether another follows.
    assign o_valid    = r_ov && !r_hold;
    assign o_data     = r_od;
    assign w_out_free = !r_ov || (o_valid && i_ready);
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;
    assign o_idle     = (r_state == ST_IDLE) && !r_ov;
    assign w_tag      = i_data.tag[SW-1:0];
    assign w_done     = (r_pend == '0) && ((r_left == '0) || r_err);
    assign w_emit     = w_out_free && !r_hold && (
                            ((r_state == ST_RET) && r_hit_ok) ||
                            ((r_state == ST_DECIDE) && w_done) ||
                            ((r_state == ST_ISSUE) && w_can_issue));

    always_comb begin
        w_chunk = r_chunk;
        if (r_chunk == '0) w_chunk = LEN_W'(1);
        if (r_chunk > LEN_W'(256)) w_chunk = LEN_W'(256);
        w_len = (r_left < {{(SECT_W-LEN_W){1'b0}}, w_chunk}) ? r_left[LEN_W-1:0] : w_chunk;
        w_can_issue = (r_left != '0) && !r_err && (r_free != '0);
        w_top = r_stack[SW'(r_free - CW'(1))];
    end

    // Priority match over slots: lowest done slot whose start is expected.
    always_comb begin
        w_hit_ok = 1'b0;
        w_hit    = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_status[i] == SS_DONE && r_slot_start[i] == r_next_ret) begin
                w_hit_ok = 1'b1;
                w_hit    = SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_cfg  <= '0;
            r_count_cfg  <= '0;
            r_chunk      <= LEN_W'(256);
            r_free       <= CW'(SLOTS);
            r_pend       <= '0;
            r_next_issue <= '0;
            r_next_ret   <= '0;
            r_left       <= '0;
            r_err        <= 1'b0;
            r_state      <= ST_IDLE;
            r_ov         <= 1'b0;
            r_hold       <= 1'b0;
            r_hit_ok     <= 1'b0;
            r_hit        <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= SS_FREE;
                r_stack[i]  <= SW'(i);
            end
        end else begin
            if (w_emit) r_ov <= 1'b1;
            else if (o_valid && i_ready) r_ov <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg.index)
                    REG_START: begin
                        r_start_cfg  <= i_cfg.data;
                        r_next_issue <= i_cfg.data;
                        r_next_ret   <= i_cfg.data;
                    end
                    REG_COUNT: begin
                        r_count_cfg <= i_cfg.data;
                        r_left      <= i_cfg.data;
                    end
                    REG_CHUNK: r_chunk <= i_cfg.data[LEN_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        if (i_data.func == FUNC_START) begin
                            r_state <= ST_ISSUE;
                        end else if (r_status[w_tag] == SS_PEND) begin
                            if (r_pend != '0) r_pend <= r_pend - CW'(1);
                            if (!i_data.error) begin
                                r_status[w_tag] <= SS_DONE;
                            end else begin
                                r_err           <= 1'b1;
                                r_status[w_tag] <= SS_FREE;
                                r_stack[SW'(r_free)] <= w_tag;
                                r_free          <= r_free + CW'(1);
                            end
                            if (i_data.final_req) r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // Register the match result ahead of the retire state.
                    r_hit    <= w_hit;
                    r_hit_ok <= w_hit_ok;
                    if (w_hit_ok) r_hold <= 1'b0;
                    r_state  <= ST_RET;
                end
                ST_RET: begin
                    if (!r_hit_ok) begin
                        r_state <= ST_DECIDE;
                    end else if (w_emit) begin
                        r_hold       <= 1'b1;
                        r_od.kind    <= KIND_RETIRE;
                        r_od.slot    <= TAG_W'(r_hit);
                        r_od.sector  <= r_slot_start[r_hit];
                        r_od.sectors <= r_slot_len[r_hit];
                        r_od.failed  <= 1'b0;
                        r_od.last    <= 1'b0;
                        r_next_ret   <= r_next_ret
                                      + {{(SECT_W-LEN_W){1'b0}}, r_slot_len[r_hit]};
                        r_status[r_hit] <= SS_FREE;
                        r_stack[SW'(r_free)] <= r_hit;
                        r_free       <= r_free + CW'(1);
                        r_state      <= ST_SCAN;
                    end
                end
                ST_DECIDE: begin
                    if (w_done) begin
                        if (r_hold) begin
                            r_hold <= 1'b0;
                        end else if (w_emit) begin
                            r_od.kind    <= KIND_DONE;
                            r_od.slot    <= '0;
                            r_od.sector  <= '0;
                            r_od.sectors <= '0;
                            r_od.failed  <= r_err;
                            r_od.last    <= 1'b1;
                            r_state      <= ST_IDLE;
                        end
                    end else begin
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (!w_can_issue) begin
                        // The held result closes the item.
                        if (r_hold) begin
                            r_od.last <= 1'b1;
                            r_hold    <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end else if (r_hold) begin
                        r_hold <= 1'b0;
                    end else if (w_emit) begin
                        r_hold       <= 1'b1;
                        r_od.kind    <= KIND_ISSUE;
                        r_od.slot    <= TAG_W'(w_top);
                        r_od.sector  <= r_next_issue;
                        r_od.sectors <= w_len;
                        r_od.failed  <= 1'b0;
                        r_od.last    <= 1'b0;
                        r_slot_start[w_top] <= r_next_issue;
                        r_slot_len[w_top]   <= w_len;
                        r_status[w_top]     <= SS_PEND;
                        r_pend       <= r_pend + CW'(1);
                        r_free       <= r_free - CW'(1);
                        r_left       <= r_left - {{(SECT_W-LEN_W){1'b0}}, w_len};
                        r_next_issue <= r_next_issue + {{(SECT_W-LEN_W){1'b0}}, w_len};
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/chunked_read_reorder_engine.sv =====
// ----------------------------------------------------------------------------
// chunked_read_reorder_engine
// Issues chunked sector reads into slots and retires them in sector order.
// ----------------------------------------------------------------------------
// A start transfer issues reads of up to chunk_sectors sectors into free slots
// (taken from a LIFO stack, so slot 15 goes first) until slots, sectors or an
// error run out. A completion transfer marks its slot done, or frees it and
// sets a sticky error on failure; a final completion then retires done chunks
// strictly in sector order, and either reports done or issues more reads.
// Each retired chunk goes through a registered match scan over all slots, then
// the retire; each issued read result is held back until it is known whether
// another follows, so last can be set. The last result of each item carries
// last. Configuration is to be written only when idle; the block itself does
// not enforce this, and the host is bound to it.
module chunked_read_reorder_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crre_in_if.sink    in_ch,
    crre_cfg_if.sink   cfg_ch,
    crre_out_if.source out_ch
);
    import crre_pkg::*;

    logic w_q_valid;
    logic w_q_ready;
    t_in  w_q_data;
    logic w_idle;

    // Front: buffer input transfers ahead of the sequencer.
    crre_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_ch.valid),
        .o_ready (in_ch.ready),
        .i_data  (in_ch.data),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    // Register writes are always accepted; the host writes only when idle.
    assign cfg_ch.ready = 1'b1;

    // Back: slot bookkeeping, retire scan and issue loop.
    crre_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_data   (w_q_data),
        .i_cfg_we (cfg_ch.valid),
        .i_cfg    (cfg_ch.data),
        .o_valid  (out_ch.valid),
        .i_ready  (out_ch.ready),
        .o_data   (out_ch.data),
        .o_idle   (w_idle)
    );

    // Done results carry last and no sector or slot; the check covers last and sector.
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.data.kind == KIND_DONE |->
            out_ch.data.last && out_ch.data.sector == '0)
        else $error("done result not clean");

    // Idle back end never shows a pending result.
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idle |-> !out_ch.valid)
        else $error("idle with result pending");

endmodule

// ===== test/crre_checker.sv =====
// ----------------------------------------------------------------------------
// crre_checker
// Watches the channels of the reorder engine, predicts and compares results.
// ----------------------------------------------------------------------------
module crre_checker
    import crre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    crre_in_if   in_ch,
    crre_cfg_if  cfg_ch,
    crre_out_if  out_ch,
    output int   o_fail_count,
    output int   o_exp_left
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;
    localparam int CHUNK_LIMIT = 256;

    typedef enum logic [1:0] {SLOT_FREE, SLOT_PEND, SLOT_DONE} t_slot_st;

    logic [SECT_W-1:0] cfg_start;
    logic [SECT_W-1:0] cfg_count;
    logic [LEN_W-1:0]  cfg_chunk;

    logic [SECT_W-1:0] chunk_base [NSLOT];
    logic [LEN_W-1:0]  chunk_len  [NSLOT];
    t_slot_st          slot_state [NSLOT];
    logic [TAG_W-1:0]  free_lifo  [NSLOT];
    int                free_depth;
    logic [SECT_W-1:0] issue_ptr;
    logic [SECT_W-1:0] retire_ptr;
    logic [SECT_W-1:0] remaining;
    logic              err_seen;
    int                in_flight;

    t_out expected_results[$];
    int   fails;

    assign o_fail_count = fails;
    assign o_exp_left   = expected_results.size();

    task automatic clear_engine();
        cfg_start = '0;
        cfg_count = '0;
        cfg_chunk = LEN_W'(CHUNK_LIMIT);
        for (int i = 0; i < NSLOT; i++) begin
            chunk_base[i] = '0;
            chunk_len[i]  = '0;
            slot_state[i] = SLOT_FREE;
            free_lifo[i]  = TAG_W'(i);
        end
        free_depth = NSLOT;
        issue_ptr  = '0;
        retire_ptr = '0;
        remaining  = '0;
        err_seen   = 1'b0;
        in_flight  = 0;
        expected_results.delete();
    endtask

    function automatic t_out make_result(logic [KIND_W-1:0] kind, int slot,
                                         logic [SECT_W-1:0] sector,
                                         logic [LEN_W-1:0] sectors, logic failed);
        t_out r;
        r.kind    = kind;
        r.slot    = TAG_W'(slot);
        r.sector  = sector;
        r.sectors = sectors;
        r.failed  = failed;
        r.last    = 1'b0;
        return r;
    endfunction

    // Fill free slots with chunks while sectors remain and no error was seen.
    task automatic issue_chunks(ref t_out res[$]);
        int chunk;
        int s;
        logic [SECT_W-1:0] len;
        chunk = (cfg_chunk == 0) ? 1 : (cfg_chunk > CHUNK_LIMIT) ? CHUNK_LIMIT : cfg_chunk;
        while (remaining != 0 && !err_seen && free_depth != 0) begin
            free_depth--;
            s = free_lifo[free_depth];
            len = (remaining < SECT_W'(chunk)) ? remaining : SECT_W'(chunk);
            chunk_base[s] = issue_ptr;
            chunk_len[s]  = LEN_W'(len);
            slot_state[s] = SLOT_PEND;
            in_flight++;
            remaining = remaining - len;
            issue_ptr = issue_ptr + len;
            res.push_back(make_result(KIND_ISSUE, s, chunk_base[s], LEN_W'(len), 1'b0));
        end
    endtask

    // Retire done chunks in sector order; lowest slot wins a tie.
    task automatic retire_chunks(ref t_out res[$]);
        int hit;
        forever begin
            hit = -1;
            for (int i = 0; i < NSLOT; i++) begin
                if (hit < 0 && slot_state[i] == SLOT_DONE && chunk_base[i] == retire_ptr)
                    hit = i;
            end
            if (hit < 0) break;
            res.push_back(make_result(KIND_RETIRE, hit, chunk_base[hit],
                                      chunk_len[hit], 1'b0));
            retire_ptr = retire_ptr + SECT_W'(chunk_len[hit]);
            slot_state[hit] = SLOT_FREE;
            if (free_depth < NSLOT) begin
                free_lifo[free_depth] = TAG_W'(hit);
                free_depth++;
            end
        end
    endtask

    task automatic predict_engine(t_in item);
        t_out res[$];
        int s;
        s = item.tag;
        if (item.func == FUNC_START) begin
            issue_chunks(res);
        end else if (slot_state[s] == SLOT_PEND) begin
            if (in_flight != 0) in_flight--;
            if (!item.error) begin
                slot_state[s] = SLOT_DONE;
            end else begin
                err_seen = 1'b1;
                slot_state[s] = SLOT_FREE;
                if (free_depth < NSLOT) begin
                    free_lifo[free_depth] = TAG_W'(s);
                    free_depth++;
                end
            end
            if (item.final_req) begin
                retire_chunks(res);
                if (in_flight == 0 && (remaining == 0 || err_seen))
                    res.push_back(make_result(KIND_DONE, 0, '0, '0, err_seen));
                else
                    issue_chunks(res);
            end
        end
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) expected_results.push_back(res[i]);
    endtask

    task automatic write_register(t_cfg w);
        case (w.index)
            REG_START: begin
                cfg_start  = w.data;
                issue_ptr  = w.data;
                retire_ptr = w.data;
            end
            REG_COUNT: begin
                cfg_count = w.data;
                remaining = w.data;
            end
            REG_CHUNK: cfg_chunk = w.data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        fails = 0;
        clear_engine();
    end

    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (!i_rst_n) begin
            clear_engine();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) write_register(cfg_ch.data);
            if (in_ch.valid && in_ch.ready) predict_engine(in_ch.data);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the chunked read reorder engine.
// ----------------------------------------------------------------------------
// Runs a series of streams, each set up through the configuration channel
// while the engine is idle. Completions are drawn from the slots the engine
// has issued and not yet seen completed, in random order, so chunks retire
// out of arrival order. Long or endless streams are cut short by clearing
// the sector count and then completing everything still outstanding. The
// error stream comes last because the error flag never clears.
module tb_top;
    import crre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 80;
    localparam int ITEM_GOAL    = 430;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   exp_left;
    int   cycles = 0;
    int   items_sent;
    logic calm = 1'b0;
    logic [TAG_W-1:0] open_slots[$];

    crre_in_if  in_ch();
    crre_cfg_if cfg_ch();
    crre_out_if out_ch();

    chunked_read_reorder_engine DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    crre_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .cfg_ch      (cfg_ch),
        .out_ch      (out_ch),
        .o_fail_count(fail_count),
        .o_exp_left  (exp_left)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Count cycles, open an idle-free window, and stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        calm   <= (cycles > 2000 && cycles < 3500);
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Track issued slots so completions only name live reads (plus noise).
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready && out_ch.data.kind == KIND_ISSUE)
            open_slots.push_back(out_ch.data.slot);
    end

    // Stall the result side about a quarter of the time.
    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 24);
    end

    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 24) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic send_item(logic func, logic [TAG_W-1:0] tag, logic err, logic fin);
        maybe_idle();
        in_ch.valid          = 1'b1;
        in_ch.data.func      = func;
        in_ch.data.tag       = tag;
        in_ch.data.error     = err;
        in_ch.data.final_req = fin;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        items_sent++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [SECT_W-1:0] value);
        in_ch.valid  = 1'b0;
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = '{index: idx, data: value};
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Hold off until no result is owed, then let any silent item finish.
    task automatic wait_quiet();
        in_ch.valid = 1'b0;
        while (exp_left != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    function automatic logic [SECT_W-1:0] rand_sector();
        return SECT_W'({$urandom, $urandom});
    endfunction

    // One stream: configure, start, then complete reads until nothing is open.
    task automatic run_stream(logic [SECT_W-1:0] first, logic [SECT_W-1:0] count,
                              logic [SECT_W-1:0] chunk, int max_items, int err_pct);
        int  n;
        int  pick;
        bit  cut;
        logic [TAG_W-1:0] tag;
        logic err;
        n = 0;
        cut = 0;
        wait_quiet();
        write_reg(REG_START, first);
        write_reg(REG_COUNT, count);
        write_reg(REG_CHUNK, chunk);
        send_item(FUNC_START, TAG_W'($urandom), 1'b0, 1'b0);
        forever begin
            while (open_slots.size() == 0 && exp_left != 0) @(negedge i_clk);
            if (open_slots.size() == 0) break;
            if (n >= max_items && !cut) begin
                // Clear the remaining count, then drain the live reads.
                wait_quiet();
                write_reg(REG_COUNT, '0);
                cut = 1;
            end
            if (n == 10) wait_quiet();
            if (!cut && $urandom_range(99) < 8) begin
                // Drop in a start or a completion for a slot not in flight.
                tag = TAG_W'($urandom);
                foreach (open_slots[i]) if (open_slots[i] == tag) tag = tag ^ 4'h8;
                foreach (open_slots[i]) if (open_slots[i] == tag) tag = tag ^ 4'h8;
                if ($urandom_range(1)) send_item(FUNC_START, tag, 1'($urandom), 1'($urandom));
                else begin
                    pick = 0;
                    foreach (open_slots[i]) if (open_slots[i] == tag) pick = 1;
                    if (!pick) send_item(FUNC_CPL, tag, 1'($urandom), 1'($urandom));
                end
            end else begin
                pick = $urandom_range(open_slots.size() - 1);
                tag = open_slots[pick];
                open_slots.delete(pick);
                err = ($urandom_range(99) < err_pct);
                send_item(FUNC_CPL, tag, err,
                          cut || open_slots.size() == 0 || $urandom_range(99) < 75);
            end
            n++;
        end
        wait_quiet();
    endtask

    initial begin
        items_sent   = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty range, stray completion, chunk below and above range,
        // sector wrap, an ignored register index, an endless range cut short.
        send_item(FUNC_CPL, 4'd7, 1'b0, 1'b1);
        run_stream('0, '0, 48'd1, 5, 0);
        run_stream(48'hFFFF_FFFF_FFFD, 48'd5, 48'd0, 20, 0);
        run_stream(48'd1000, 48'd600, 48'd511, 20, 0);
        wait_quiet();
        write_reg(2'd3, rand_sector());
        run_stream(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd256, 20, 0);

        // Random streams; small chunks mostly so slots get reused often.
        while (items_sent < ITEM_GOAL - 60) begin
            run_stream(rand_sector(), 48'($urandom_range(1, 2000)),
                       ($urandom_range(3) == 0) ? 48'($urandom_range(1, 256))
                                                : 48'($urandom_range(1, 24)),
                       $urandom_range(20, 60), 0);
        end

        // Errors last: the flag is sticky for the rest of the run.
        run_stream(rand_sector(), 48'd3000, 48'($urandom_range(1, 64)), 60, 6);
        repeat (4) send_item(FUNC_START, TAG_W'($urandom), 1'b1, 1'b1);
        wait_quiet();

        if (fail_count == 0 && exp_left == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/crre_pkg.sv
sv/crre_if.sv
sv/crre_front.sv
sv/crre_back.sv
sv/chunked_read_reorder_engine.sv
test/crre_checker.sv
test/tb_top.sv
